// ----- hdl/lsps_pkg.sv -----
// Shared types, constants and helpers of the light style pattern sequencer.
// No dependencies; used by every other file of the block except lsps_ram.
package lsps_pkg;

  // Default sizes of the pattern store
  localparam int NUM_STYLES  = 64;
  localparam int MAX_PATTERN = 64;

  // Field widths
  localparam int REQ_W    = 2;
  localparam int STYLE_W  = 6;
  localparam int POS_W    = 6;
  localparam int LETTER_W = 8;
  localparam int PLEN_W   = 7;
  localparam int TICK_W   = 31;
  localparam int BRIGHT_W = 13;
  localparam int CFG_W    = 2;
  localparam int CFG_IDX_W = 1;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_LETTER = 2'd0,
    REQ_HEADER = 2'd1,
    REQ_EVAL   = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FLAT_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_MODE = 1'd1;

  // Flat mode codes (code three animates like zero)
  localparam logic [1:0] FLAT_ANIM = 2'd0;
  localparam logic [1:0] FLAT_AVG  = 2'd1;
  localparam logic [1:0] FLAT_PEAK = 2'd2;

  // Letter codes and brightness scale
  localparam logic [LETTER_W-1:0] LETTER_BASE = 8'd97;  // 'a', darkness
  localparam logic [LETTER_W-1:0] DIGIT_LO    = 8'd49;  // '1'
  localparam logic [LETTER_W-1:0] DIGIT_HI    = 8'd51;  // '3'
  localparam logic [BRIGHT_W-1:0] LEVEL_STEP  = 13'd22;
  localparam logic [BRIGHT_W-1:0] UNUSED_LEVEL = 13'd256;

  // (letter - 'a') * 22, wrapped to 13 bits two's complement
  function automatic logic [BRIGHT_W-1:0] level_of(input logic [LETTER_W-1:0] letter);
    logic [BRIGHT_W-1:0] diff;
    diff = BRIGHT_W'(letter) - BRIGHT_W'(LETTER_BASE);
    return BRIGHT_W'(diff * LEVEL_STEP);
  endfunction

endpackage

// ----- hdl/lsps_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lsps_ram #(
  parameter int Width = 8,
  parameter int Depth = 64,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/lsps_mod_serial.sv -----
// Bit-serial restoring modulo unit: remainder of a tick count by a pattern length.
// Depends on lsps_pkg for the tick width.
module lsps_mod_serial #(
  parameter int LenW = 7
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [lsps_pkg::TICK_W-1:0] dividend_i,
  input  logic [LenW-1:0]            divisor_i,
  output logic                       done_o,
  output logic [LenW-1:0]            rem_o
);

  localparam int CntW = $clog2(lsps_pkg::TICK_W + 1);

  logic [lsps_pkg::TICK_W-1:0] shift_q;
  logic [LenW-1:0]             div_q;
  logic [LenW-1:0]             rem_q, rem_d;
  logic [CntW-1:0]             cnt_q;
  logic                        run_q, done_q;
  logic [LenW:0]               trial;

  // one quotient bit per cycle: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_q, shift_q[lsps_pkg::TICK_W-1]};
    if (trial >= {1'b0, div_q}) begin
      rem_d = LenW'(trial - {1'b0, div_q});
    end else begin
      rem_d = LenW'(trial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      shift_q <= '0;
      div_q   <= '0;
      rem_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q   <= 1'b1;
        cnt_q   <= CntW'(lsps_pkg::TICK_W);
        shift_q <= dividend_i;
        div_q   <= divisor_i;
        rem_q   <= '0;
      end else if (run_q) begin
        rem_q   <= rem_d;
        shift_q <= {shift_q[lsps_pkg::TICK_W-2:0], 1'b0};
        cnt_q   <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ----- hdl/light_style_pattern_sequencer_unit.sv -----
// Light style pattern sequencer, top level: request decode, pattern stores and
// the per-style evaluation sequencer. Depends on lsps_pkg, lsps_ram, lsps_mod_serial.
//
// Usage:
//   A request is taken at a rising edge with start_i high and busy_o low.
//   Letter and header writes finish in that edge and give no result; busy_o
//   stays low, so a request may follow every cycle.
//   An evaluate request raises busy_o and walks all styles in order, giving one
//   beat per style on result_valid_o for exactly one cycle with result_style_o,
//   brightness_o and last_style_o (high on the final style).
//   Per style: header read and decision only when the result needs no pattern
//   lookup (unused style, flat modes, rate digit with length one); when animating,
//   the bit-serial modulo unit then works through the dividend bit by bit and
//   raises its done flag, and the letter read follows.
//   The last beat of a run shows in the same cycle in which busy_o drops.
//   Configuration writes (cfg_we_i) take effect at once; issue them while idle.
//   Reset clears the configuration and marks every style unused; pattern
//   letters, peak and average letters are undefined until written. No clearing
//   pass is needed: the block takes requests right after reset.
//   The receiver cannot stall: each result beat is shown for one cycle only.
module light_style_pattern_sequencer_unit #(
  parameter int NumStyles  = lsps_pkg::NUM_STYLES,
  parameter int MaxPattern = lsps_pkg::MAX_PATTERN
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration write port
  input  logic                               cfg_we_i,
  input  logic [lsps_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [lsps_pkg::CFG_W-1:0]         cfg_wdata_i,
  // request channel
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [lsps_pkg::REQ_W-1:0]         req_type_i,
  input  logic [lsps_pkg::STYLE_W-1:0]       style_number_i,
  input  logic [lsps_pkg::POS_W-1:0]         letter_position_i,
  input  logic [lsps_pkg::LETTER_W-1:0]      letter_code_i,
  input  logic [lsps_pkg::PLEN_W-1:0]        pattern_length_i,
  input  logic [lsps_pkg::LETTER_W-1:0]      peak_code_i,
  input  logic [lsps_pkg::LETTER_W-1:0]      average_code_i,
  input  logic [lsps_pkg::TICK_W-1:0]        tick_10hz_i,
  input  logic [lsps_pkg::TICK_W-1:0]        tick_20hz_i,
  input  logic [lsps_pkg::TICK_W-1:0]        tick_30hz_i,
  // result channel
  output logic                               result_valid_o,
  output logic [lsps_pkg::STYLE_W-1:0]       result_style_o,
  output logic signed [lsps_pkg::BRIGHT_W-1:0] brightness_o,
  output logic                               last_style_o
);

  localparam int SW     = (NumStyles > 1) ? $clog2(NumStyles) : 1;
  localparam int LW     = $clog2(MaxPattern + 1);
  localparam int LDepth = NumStyles * MaxPattern;
  localparam int AW     = (LDepth > 1) ? $clog2(LDepth) : 1;
  localparam int HW     = LW + 2 * lsps_pkg::LETTER_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_HDR,
    ST_DECIDE,
    ST_DIV,
    ST_LWAIT
  } state_e;

  state_e state_q;

  // configuration registers
  logic [1:0] flat_mode_q;
  logic       rate_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flat_mode_q <= lsps_pkg::FLAT_ANIM;
      rate_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lsps_pkg::CFG_FLAT_MODE: flat_mode_q <= cfg_wdata_i;
        lsps_pkg::CFG_RATE_MODE: rate_mode_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // request decode
  logic accept, style_ok, pos_ok;
  logic let_we, hdr_we, eval_go;

  assign accept   = start_i && !busy_o;
  assign style_ok = int'(style_number_i) < NumStyles;
  assign pos_ok   = int'(letter_position_i) < MaxPattern;
  assign let_we   = accept && (req_type_i == lsps_pkg::REQ_LETTER) && style_ok && pos_ok;
  assign hdr_we   = accept && (req_type_i == lsps_pkg::REQ_HEADER) && style_ok;
  assign eval_go  = accept && (req_type_i == lsps_pkg::REQ_EVAL);

  // write addresses and header word
  logic [AW-1:0] let_waddr;
  logic [SW-1:0] hdr_waddr;
  logic [LW-1:0] len_sat;
  logic [HW-1:0] hdr_wdata;

  assign let_waddr = AW'(int'(style_number_i) * MaxPattern + int'(letter_position_i));
  assign hdr_waddr = SW'(style_number_i);
  assign len_sat   = (int'(pattern_length_i) > MaxPattern) ? LW'(MaxPattern)
                                                           : LW'(pattern_length_i);
  assign hdr_wdata = {len_sat, peak_code_i, average_code_i};

  // header-written flags, one per style; unwritten style reads as length zero
  logic [NumStyles-1:0] hdr_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_valid_q <= '0;
    end else if (hdr_we) begin
      hdr_valid_q[hdr_waddr] <= 1'b1;
    end
  end

  // evaluation registers
  logic [SW-1:0]               s_q;
  logic [AW-1:0]               base_q;
  logic [lsps_pkg::TICK_W-1:0] t10_q, t20_q, t30_q;
  logic                        hv_q;
  logic                        off_q;

  // memory ports
  logic                          let_re, hdr_re;
  logic [AW-1:0]                 let_raddr;
  logic [lsps_pkg::LETTER_W-1:0] let_rdata;
  logic [HW-1:0]                 hdr_rdata;

  // modulo unit ports
  logic                        div_start, div_done;
  logic [lsps_pkg::TICK_W-1:0] div_dividend;
  logic [LW-1:0]               div_divisor, div_rem;

  // header fields
  logic [LW-1:0]                 cur_len;
  logic [lsps_pkg::LETTER_W-1:0] cur_peak, cur_avg;

  assign cur_len  = hv_q ? hdr_rdata[HW-1 -: LW] : '0;
  assign cur_peak = hdr_rdata[2*lsps_pkg::LETTER_W-1 -: lsps_pkg::LETTER_W];
  assign cur_avg  = hdr_rdata[lsps_pkg::LETTER_W-1:0];

  // per-style decision: immediate level or a modulo lookup
  logic                        imm_hit;
  logic [lsps_pkg::BRIGHT_W-1:0] imm_level;
  logic                        use_off;

  always_comb begin
    imm_hit      = 1'b0;
    imm_level    = lsps_pkg::UNUSED_LEVEL;
    use_off      = 1'b0;
    div_dividend = t10_q;
    div_divisor  = cur_len;
    if (cur_len == '0) begin
      imm_hit = 1'b1;
    end else if (flat_mode_q == lsps_pkg::FLAT_PEAK) begin
      imm_hit   = 1'b1;
      imm_level = lsps_pkg::level_of(cur_peak);
    end else if (flat_mode_q == lsps_pkg::FLAT_AVG) begin
      imm_hit   = 1'b1;
      imm_level = lsps_pkg::level_of(cur_avg);
    end else if (rate_mode_q &&
                 (let_rdata inside {[lsps_pkg::DIGIT_LO:lsps_pkg::DIGIT_HI]})) begin
      if (cur_len == LW'(1)) begin
        imm_hit = 1'b1;
      end else begin
        use_off     = 1'b1;
        div_divisor = cur_len - LW'(1);
        case (let_rdata)
          lsps_pkg::DIGIT_LO: div_dividend = t10_q;
          lsps_pkg::DIGIT_HI: div_dividend = t30_q;
          default:            div_dividend = t20_q;
        endcase
      end
    end
  end

  assign div_start = (state_q == ST_DECIDE) && !imm_hit;
  assign hdr_re    = (state_q == ST_RD_HDR);
  assign let_re    = (state_q == ST_RD_HDR) || ((state_q == ST_DIV) && div_done);
  assign let_raddr = (state_q == ST_RD_HDR) ? base_q
                                            : AW'(base_q + AW'(div_rem) + AW'(off_q));

  // result beat register
  logic                          out_valid_q;
  logic [lsps_pkg::STYLE_W-1:0]  out_style_q;
  logic [lsps_pkg::BRIGHT_W-1:0] out_level_q;
  logic                          out_last_q;
  logic                          is_last;

  assign is_last = (s_q == SW'(NumStyles - 1));

  // sequencer: state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      s_q         <= '0;
      base_q      <= '0;
      t10_q       <= '0;
      t20_q       <= '0;
      t30_q       <= '0;
      hv_q        <= 1'b0;
      off_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_style_q <= '0;
      out_level_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (eval_go) begin
            s_q     <= '0;
            base_q  <= '0;
            t10_q   <= tick_10hz_i;
            t20_q   <= tick_20hz_i;
            t30_q   <= tick_30hz_i;
            state_q <= ST_RD_HDR;
          end
        end
        ST_RD_HDR: begin
          hv_q    <= hdr_valid_q[s_q];
          state_q <= ST_DECIDE;
        end
        ST_DECIDE: begin
          off_q <= use_off;
          if (imm_hit) begin
            out_valid_q <= 1'b1;
            out_style_q <= lsps_pkg::STYLE_W'(s_q);
            out_level_q <= imm_level;
            out_last_q  <= is_last;
            s_q         <= s_q + 1'b1;
            base_q      <= AW'(base_q + AW'(MaxPattern));
            state_q     <= is_last ? ST_IDLE : ST_RD_HDR;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_LWAIT;
          end
        end
        ST_LWAIT: begin
          out_valid_q <= 1'b1;
          out_style_q <= lsps_pkg::STYLE_W'(s_q);
          out_level_q <= lsps_pkg::level_of(let_rdata);
          out_last_q  <= is_last;
          s_q         <= s_q + 1'b1;
          base_q      <= AW'(base_q + AW'(MaxPattern));
          state_q     <= is_last ? ST_IDLE : ST_RD_HDR;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = out_valid_q;
  assign result_style_o = out_style_q;
  assign brightness_o   = out_level_q;
  assign last_style_o   = out_last_q;

  // pattern letter store
  lsps_ram #(
    .Width (lsps_pkg::LETTER_W),
    .Depth (LDepth)
  ) u_letter_ram (
    .clk_i   (clk_i),
    .we_i    (let_we),
    .waddr_i (let_waddr),
    .wdata_i (letter_code_i),
    .re_i    (let_re),
    .raddr_i (let_raddr),
    .rdata_o (let_rdata)
  );

  // style header store: length, peak letter, average letter
  lsps_ram #(
    .Width (HW),
    .Depth (NumStyles)
  ) u_header_ram (
    .clk_i   (clk_i),
    .we_i    (hdr_we),
    .waddr_i (hdr_waddr),
    .wdata_i (hdr_wdata),
    .re_i    (hdr_re),
    .raddr_i (s_q),
    .rdata_o (hdr_rdata)
  );

  // tick modulo pattern length (length minus one after a rate digit), one bit per cycle
  lsps_mod_serial #(
    .LenW (LW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

endmodule

// ----- tb/lsps_brightness_checker.sv -----
// Brightness checker for the light style pattern sequencer: mirrors the pattern
// store and configuration, predicts every result beat and compares it.
// Depends on lsps_pkg.
module lsps_brightness_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lsps_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lsps_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                                start_i,
  input  logic                                busy_i,
  input  logic [lsps_pkg::REQ_W-1:0]          req_type_i,
  input  logic [lsps_pkg::STYLE_W-1:0]        style_number_i,
  input  logic [lsps_pkg::POS_W-1:0]          letter_position_i,
  input  logic [lsps_pkg::LETTER_W-1:0]       letter_code_i,
  input  logic [lsps_pkg::PLEN_W-1:0]         pattern_length_i,
  input  logic [lsps_pkg::LETTER_W-1:0]       peak_code_i,
  input  logic [lsps_pkg::LETTER_W-1:0]       average_code_i,
  input  logic [lsps_pkg::TICK_W-1:0]         tick_10hz_i,
  input  logic [lsps_pkg::TICK_W-1:0]         tick_20hz_i,
  input  logic [lsps_pkg::TICK_W-1:0]         tick_30hz_i,
  input  logic                                result_valid_i,
  input  logic [lsps_pkg::STYLE_W-1:0]        result_style_i,
  input  logic signed [lsps_pkg::BRIGHT_W-1:0] brightness_i,
  input  logic                                last_style_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);
  import lsps_pkg::*;

  typedef struct packed {
    logic [STYLE_W-1:0]  style;
    logic [BRIGHT_W-1:0] level;
    logic                last;
  } style_level_t;

  // Mirror of the pattern store and configuration
  logic [LETTER_W-1:0] letters [NUM_STYLES][MAX_PATTERN];
  logic [PLEN_W-1:0]   lengths [NUM_STYLES];
  logic [LETTER_W-1:0] peaks   [NUM_STYLES];
  logic [LETTER_W-1:0] avgs    [NUM_STYLES];
  logic [1:0]          flat_mode;
  logic                rate_mode;

  style_level_t expected_levels [$];

  // (letter - 'a') * 22, kept to the low 13 bits
  function automatic logic [BRIGHT_W-1:0] letter_level(input logic [LETTER_W-1:0] code);
    int v;
    v = (int'(code) - int'(LETTER_BASE)) * int'(LEVEL_STEP);
    return v[BRIGHT_W-1:0];
  endfunction

  // Brightness of one style for the given time counts
  function automatic logic [BRIGHT_W-1:0] style_brightness(input int s,
      input logic [TICK_W-1:0] t10, input logic [TICK_W-1:0] t20,
      input logic [TICK_W-1:0] t30);
    int unsigned len;
    int unsigned tick;
    logic [LETTER_W-1:0] lead;
    logic [LETTER_W-1:0] pick;
    len = lengths[s];
    if (len == 0) return UNUSED_LEVEL;
    if (flat_mode == FLAT_PEAK) return letter_level(peaks[s]);
    if (flat_mode == FLAT_AVG) return letter_level(avgs[s]);
    lead = letters[s][0];
    if (rate_mode && lead >= DIGIT_LO && lead <= DIGIT_HI) begin
      // leading digit picks the rate; the digit itself is not part of the loop
      if (len == 1) return UNUSED_LEVEL;
      case (lead - DIGIT_LO)
        8'd0:    tick = t10;
        8'd1:    tick = t20;
        default: tick = t30;
      endcase
      pick = letters[s][tick % (len - 1) + 1];
    end else begin
      tick = t10;
      pick = letters[s][tick % len];
    end
    return letter_level(pick);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    style_level_t want;
    style_level_t got;
    if (!rst_ni) begin
      for (int s = 0; s < NUM_STYLES; s++) lengths[s] = '0;
      flat_mode = FLAT_ANIM;
      rate_mode = 1'b0;
      expected_levels.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      // result beat against the oldest expectation
      if (result_valid_i) begin
        if (expected_levels.size() == 0) begin
          $error("result beat for style %0d with nothing expected", result_style_i);
          fail_count_o++;
        end else begin
          want = expected_levels.pop_front();
          got = '{style: result_style_i, level: brightness_i, last: last_style_i};
          if (got.style !== want.style) begin
            $error("result_style: expected %0d, got %0d", want.style, got.style);
            fail_count_o++;
          end
          if (got.level !== want.level) begin
            $error("brightness (style %0d): expected %0d, got %0d", want.style,
                   $signed(want.level), $signed(got.level));
            fail_count_o++;
          end
          if (got.last !== want.last) begin
            $error("last_style (style %0d): expected %0b, got %0b", want.style,
                   want.last, got.last);
            fail_count_o++;
          end
        end
      end

      // configuration writes
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_FLAT_MODE) flat_mode = cfg_wdata_i[1:0];
        else if (cfg_idx_i == CFG_RATE_MODE) rate_mode = cfg_wdata_i[0];
      end

      // accepted request beat; style and position ports cannot exceed the store
      if (start_i && !busy_i) begin
        case (req_e'(req_type_i))
          REQ_LETTER: letters[style_number_i][letter_position_i] = letter_code_i;
          REQ_HEADER: begin
            lengths[style_number_i] = (pattern_length_i > MAX_PATTERN) ?
                                      PLEN_W'(MAX_PATTERN) : pattern_length_i;
            peaks[style_number_i] = peak_code_i;
            avgs[style_number_i] = average_code_i;
          end
          REQ_EVAL: begin
            for (int s = 0; s < NUM_STYLES; s++) begin
              want.style = STYLE_W'(s);
              want.level = style_brightness(s, tick_10hz_i, tick_20hz_i, tick_30hz_i);
              want.last = (s == NUM_STYLES - 1);
              expected_levels.push_back(want);
            end
          end
          default: ;
        endcase
      end
      pending_o = expected_levels.size();
    end
  end

endmodule

// ----- tb/light_style_pattern_sequencer_unit_test.sv -----
// Testbench top of the light style pattern sequencer: clock, reset, directed and
// random request beats, configuration phases and the verdict.
// Depends on lsps_pkg, light_style_pattern_sequencer_unit and lsps_brightness_checker.
module light_style_pattern_sequencer_unit_test;
  import lsps_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 60;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 3;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 start_i;
  logic                 busy_o;
  logic [REQ_W-1:0]     req_type_i;
  logic [STYLE_W-1:0]   style_number_i;
  logic [POS_W-1:0]     letter_position_i;
  logic [LETTER_W-1:0]  letter_code_i;
  logic [PLEN_W-1:0]    pattern_length_i;
  logic [LETTER_W-1:0]  peak_code_i;
  logic [LETTER_W-1:0]  average_code_i;
  logic [TICK_W-1:0]    tick_10hz_i;
  logic [TICK_W-1:0]    tick_20hz_i;
  logic [TICK_W-1:0]    tick_30hz_i;
  logic                 result_valid_o;
  logic [STYLE_W-1:0]   result_style_o;
  logic signed [BRIGHT_W-1:0] brightness_o;
  logic                 last_style_o;

  int fail_count;
  int pending_levels;
  int unsigned cycle_count = 0;
  int idle_pct = 0;
  int sent_items = 0;

  // letters written so far; a header never covers an unwritten position
  bit [MAX_PATTERN-1:0] letter_written [NUM_STYLES];

  light_style_pattern_sequencer_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .start_i, .busy_o,
    .req_type_i, .style_number_i, .letter_position_i, .letter_code_i,
    .pattern_length_i, .peak_code_i, .average_code_i,
    .tick_10hz_i, .tick_20hz_i, .tick_30hz_i,
    .result_valid_o, .result_style_o, .brightness_o, .last_style_o
  );

  lsps_brightness_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i, .start_i,
    .busy_i(busy_o), .req_type_i, .style_number_i, .letter_position_i,
    .letter_code_i, .pattern_length_i, .peak_code_i, .average_code_i,
    .tick_10hz_i, .tick_20hz_i, .tick_30hz_i,
    .result_valid_i(result_valid_o), .result_style_i(result_style_o),
    .brightness_i(brightness_o), .last_style_i(last_style_o),
    .fail_count_o(fail_count), .pending_o(pending_levels)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int written_prefix(input int s);
    int n;
    n = 0;
    while (n < MAX_PATTERN && letter_written[s][n]) n++;
    return n;
  endfunction

  // mostly 'a'..'z', rate digits and their neighbors up front, some raw bytes
  function automatic logic [LETTER_W-1:0] pattern_letter(input int pos);
    int r;
    r = $urandom_range(99);
    if (pos == 0 && r < 35) return LETTER_W'($urandom_range(48, 52));
    if (r < 85) return LETTER_W'($urandom_range(97, 122));
    return LETTER_W'($urandom_range(255));
  endfunction

  function automatic logic [TICK_W-1:0] rand_tick();
    int r;
    r = $urandom_range(99);
    if (r < 15) return '0;
    if (r < 25) return '1;
    if (r < 55) return TICK_W'($urandom_range(200));
    return TICK_W'($urandom());
  endfunction

  task automatic idle_for(input int n);
    start_i <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  // one request beat; called and returns at a falling edge
  task automatic send(input req_e rq, input logic [STYLE_W-1:0] s,
      input logic [POS_W-1:0] p, input logic [LETTER_W-1:0] c,
      input logic [PLEN_W-1:0] plen, input logic [LETTER_W-1:0] pk,
      input logic [LETTER_W-1:0] av, input logic [TICK_W-1:0] t10,
      input logic [TICK_W-1:0] t20, input logic [TICK_W-1:0] t30);
    if ($urandom_range(99) < idle_pct) idle_for($urandom_range(1, 40));
    req_type_i        <= rq;
    style_number_i    <= s;
    letter_position_i <= p;
    letter_code_i     <= c;
    pattern_length_i  <= plen;
    peak_code_i       <= pk;
    average_code_i    <= av;
    tick_10hz_i       <= t10;
    tick_20hz_i       <= t20;
    tick_30hz_i       <= t30;
    start_i           <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
    if (rq == REQ_LETTER) letter_written[s][p] = 1'b1;
    if (rq != REQ_NONE) sent_items++;
  endtask

  // unused fields of each beat carry random noise
  task automatic put_letter(input int s, input int p, input logic [LETTER_W-1:0] c);
    send(REQ_LETTER, STYLE_W'(s), POS_W'(p), c, PLEN_W'($urandom()),
         LETTER_W'($urandom()), LETTER_W'($urandom()), TICK_W'($urandom()),
         TICK_W'($urandom()), TICK_W'($urandom()));
  endtask

  task automatic put_header(input int s, input int len, input logic [LETTER_W-1:0] pk,
      input logic [LETTER_W-1:0] av);
    send(REQ_HEADER, STYLE_W'(s), POS_W'($urandom()), LETTER_W'($urandom()),
         PLEN_W'(len), pk, av, TICK_W'($urandom()), TICK_W'($urandom()),
         TICK_W'($urandom()));
  endtask

  task automatic evaluate(input logic [TICK_W-1:0] t10, input logic [TICK_W-1:0] t20,
      input logic [TICK_W-1:0] t30);
    send(REQ_EVAL, STYLE_W'($urandom()), POS_W'($urandom()), LETTER_W'($urandom()),
         PLEN_W'($urandom()), LETTER_W'($urandom()), LETTER_W'($urandom()),
         t10, t20, t30);
  endtask

  task automatic no_op();
    send(REQ_NONE, STYLE_W'($urandom()), POS_W'($urandom()), LETTER_W'($urandom()),
         PLEN_W'($urandom()), LETTER_W'($urandom()), LETTER_W'($urandom()),
         TICK_W'($urandom()), TICK_W'($urandom()), TICK_W'($urandom()));
  endtask

  // fill the missing letters (and redo some), then the header
  task automatic build_style(input int s, input int len);
    int top_pos;
    top_pos = (len > MAX_PATTERN) ? MAX_PATTERN : len;
    for (int p = 0; p < top_pos; p++)
      if (!letter_written[s][p] || $urandom_range(99) < 25) put_letter(s, p, pattern_letter(p));
    put_header(s, len, pattern_letter(1), pattern_letter(1));
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (pending_levels != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic random_phase(input int phase);
    int start_count;
    int r;
    int s;
    int len;
    int pre;
    start_count = sent_items;
    // make sure one style holds a full pattern so long headers are legal
    if (phase == 0) build_style($urandom_range(NUM_STYLES - 1), $urandom_range(64, 127));
    while (sent_items - start_count < PHASE_ITEMS) begin
      r = $urandom_range(99);
      s = $urandom_range(NUM_STYLES - 1);
      if (r < 45) begin
        pre = $urandom_range(99);
        if (pre < 85) len = $urandom_range(1, 8);
        else if (pre < 95) len = $urandom_range(9, 63);
        else len = $urandom_range(64, 127);
        build_style(s, len);
      end else if (r < 70) begin
        evaluate(rand_tick(), rand_tick(), rand_tick());
      end else if (r < 82) begin
        put_letter(s, $urandom_range(MAX_PATTERN - 1), LETTER_W'($urandom()));
      end else if (r < 92) begin
        // header over what is already written, zero length included
        pre = written_prefix(s);
        len = (pre >= MAX_PATTERN) ? $urandom_range(127) : $urandom_range(pre);
        put_header(s, len, LETTER_W'($urandom()), LETTER_W'($urandom()));
      end else begin
        no_op();
      end
    end
    evaluate(rand_tick(), rand_tick(), rand_tick());
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    start_i = 1'b0;
    req_type_i = REQ_NONE;
    style_number_i = '0;
    letter_position_i = '0;
    letter_code_i = '0;
    pattern_length_i = '0;
    peak_code_i = '0;
    average_code_i = '0;
    tick_10hz_i = '0;
    tick_20hz_i = '0;
    tick_30hz_i = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: every style unused, then a few hand-made patterns
    evaluate('0, '0, '0);
    put_letter(0, 0, 8'd97);
    put_letter(0, 1, 8'd122);
    put_header(0, 2, 8'd122, 8'd109);
    // rate digit '2' and a two-letter loop, three letters in all
    put_letter(1, 0, 8'd50);
    put_letter(1, 1, 8'd109);
    put_letter(1, 2, 8'd98);
    put_header(1, 3, 8'd109, 8'd98);
    // rate digit with a length of one
    put_letter(2, 0, 8'd49);
    put_header(2, 1, 8'd97, 8'd97);
    // extreme bytes on the last style
    put_letter(NUM_STYLES - 1, 0, 8'hFF);
    put_letter(NUM_STYLES - 1, 1, 8'h00);
    put_header(NUM_STYLES - 1, 2, 8'hFF, 8'h00);
    put_header(5, 0, 8'h00, 8'hFF);
    no_op();
    evaluate('1, '1, '1);
    evaluate(TICK_W'(1), TICK_W'(2), TICK_W'(5));

    // random phases, each under its own configuration and one of three idle settings
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      write_cfg(CFG_FLAT_MODE, CFG_W'(phase % 4));
      write_cfg(CFG_RATE_MODE, CFG_W'((phase + phase / 4) % 2));
      case ((phase / 2) % 4)
        0: idle_pct = 0;
        1: idle_pct = 69;
        2: idle_pct = 0;
        default: idle_pct = 27;
      endcase
      random_phase(phase);
    end

    drain();
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/lsps_pkg.sv
hdl/lsps_ram.sv
hdl/lsps_mod_serial.sv
hdl/light_style_pattern_sequencer_unit.sv
tb/lsps_brightness_checker.sv
tb/light_style_pattern_sequencer_unit_test.sv
